FILE: sv/pmb_pkg.sv
// ----------------------------------------------------------------------------
// pmb_pkg: shared types and constants for peak mass binning
// Field widths, the peak and bin word types, the word that passes between
// the front and back parts, and the register and state codes.
// ----------------------------------------------------------------------------
package pmb_pkg;

  localparam int MASS_BITS      = 40;
  localparam int MASS_FRAC_BITS = 20;
  localparam int PROB_BITS      = 32;

  // Bin center and end are signed and two bits wider than a mass.
  localparam int CTR_BITS = MASS_BITS + 2;
  // Numerator 2*mass + w - 2*o, signed.
  localparam int NUM_BITS = MASS_BITS + 3;
  // Magnitude of the numerator.
  localparam int MAG_BITS = MASS_BITS + 2;
  // Denominator 2*w.
  localparam int DEN_BITS = MASS_BITS + 1;
  // Remainder plus the bit shifted in.
  localparam int REM_BITS = MASS_BITS + 2;
  localparam int DIV_CNT_BITS = $clog2(MAG_BITS + 1);

  localparam logic [MASS_BITS-1:0] WIDTH_RESET = MASS_BITS'(1) << MASS_FRAC_BITS;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [0:0] {
    REG_BIN_WIDTH  = 1'b0,
    REG_BIN_OFFSET = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_CTR,
    FS_PUSH
  } front_state_t;

  typedef struct packed {
    logic [MASS_BITS-1:0] mass;
    logic [PROB_BITS-1:0] prob;
    logic                 last;
  } peak_t;

  typedef struct packed {
    logic signed [CTR_BITS-1:0] bin_center;
    logic [PROB_BITS-1:0]       prob_sum;
    logic                       last_bin;
  } bin_t;

  typedef struct packed {
    logic [MASS_BITS-1:0]       mass;
    logic [PROB_BITS-1:0]       prob;
    logic                       last;
    logic signed [CTR_BITS-1:0] center;
    logic signed [CTR_BITS-1:0] bin_end;
  } mid_item_t;

endpackage

FILE: sv/pmb_fifo.sv
// ----------------------------------------------------------------------------
// pmb_fifo: small register queue
// Holds words of a fixed width; the oldest word is shown while not empty.
// ----------------------------------------------------------------------------
module pmb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wptr;
  logic [PTR_BITS-1:0] rptr;
  logic [CNT_BITS-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign full  = (count == CNT_BITS'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_BITS'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_BITS'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/pmb_front.sv
// ----------------------------------------------------------------------------
// pmb_front: peak intake and bin placement
// Holds the configuration registers, accepts a peak and finds the center
// and end of the bin it would open, using a bit-serial remainder unit.
// ----------------------------------------------------------------------------
module pmb_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  pmb_pkg::cfg_reg_t                  cfg_index,
  input  logic [pmb_pkg::MASS_BITS-1:0]      cfg_data,
  input  logic                               push,
  output logic                               full,
  input  pmb_pkg::peak_t                     peak,
  output logic                               mid_push,
  output pmb_pkg::mid_item_t                 mid_item,
  input  logic                               mid_full
);

  import pmb_pkg::*;

  front_state_t state;
  front_state_t state_next;

  logic [MASS_BITS-1:0]       width_reg;
  logic [MASS_BITS-1:0]       offset_reg;
  logic [MASS_BITS-1:0]       w;
  logic [MASS_BITS-1:0]       o;
  logic signed [NUM_BITS-1:0] num;
  logic                       neg;
  logic [MAG_BITS-1:0]        mag;
  logic [REM_BITS-1:0]        rem;
  logic [DIV_CNT_BITS-1:0]    cnt;
  logic signed [CTR_BITS-1:0] center;
  peak_t                      item;

  logic                       accept;
  logic [MASS_BITS-1:0]       w_eff;
  logic signed [NUM_BITS-1:0] num_in;
  logic [DEN_BITS-1:0]        den;
  logic [REM_BITS-1:0]        rem_s;
  logic [REM_BITS-1:0]        r_floor;
  logic signed [NUM_BITS-1:0] diff;
  logic signed [NUM_BITS-1:0] ctr_full;

  assign cfg_ready = 1'b1;
  assign full      = (state != FS_IDLE);
  assign accept    = push && (state == FS_IDLE);
  assign w_eff     = (width_reg == '0) ? MASS_BITS'(1) : width_reg;
  assign num_in    = $signed({2'b00, peak.mass, 1'b0}) + $signed({3'b000, w_eff})
                   - $signed({2'b00, offset_reg, 1'b0});
  assign den       = {w, 1'b0};
  assign rem_s     = {rem[REM_BITS-2:0], mag[MAG_BITS-1]};
  // Floor remainder: for a negative numerator the truncating remainder flips.
  assign r_floor   = (neg && rem != '0) ? (REM_BITS'(den) - rem) : rem;
  assign diff      = num - $signed({1'b0, r_floor});
  assign ctr_full  = (diff >>> 1) + $signed({3'b000, o});

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      offset_reg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BIN_WIDTH:  width_reg  <= cfg_data;
        REG_BIN_OFFSET: offset_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      FS_IDLE: begin
        if (accept) begin
          item <= peak;
          w    <= w_eff;
          o    <= offset_reg;
          num  <= num_in;
          neg  <= num_in[NUM_BITS-1];
          mag  <= num_in[NUM_BITS-1] ? MAG_BITS'(-num_in) : MAG_BITS'(num_in);
          rem  <= '0;
          cnt  <= '0;
        end
      end
      FS_DIV: begin
        rem <= (rem_s >= REM_BITS'(den)) ? (rem_s - REM_BITS'(den)) : rem_s;
        mag <= mag << 1;
        cnt <= cnt + 1'b1;
      end
      FS_CTR: begin
        center <= CTR_BITS'(ctr_full);
      end
      FS_PUSH: ;
      default: ;
    endcase
  end

  always_comb begin
    state_next             = state;
    mid_push               = 1'b0;
    mid_item.mass          = item.mass;
    mid_item.prob          = item.prob;
    mid_item.last          = item.last;
    mid_item.center        = center;
    mid_item.bin_end       = center + $signed({2'b00, w >> 1});
    unique case (state)
      FS_IDLE: begin
        if (accept) begin
          state_next = FS_DIV;
        end
      end
      FS_DIV: begin
        if (cnt == DIV_CNT_BITS'(MAG_BITS - 1)) begin
          state_next = FS_CTR;
        end
      end
      FS_CTR: begin
        state_next = FS_PUSH;
      end
      FS_PUSH: begin
        mid_push = 1'b1;
        if (!mid_full) begin
          state_next = FS_IDLE;
        end
      end
      default: state_next = FS_IDLE;
    endcase
  end

endmodule

FILE: sv/pmb_back.sv
// ----------------------------------------------------------------------------
// pmb_back: bin accumulator
// Adds placed peaks into the open bin, closes and flushes bins, and writes
// finished bins to the result queue.
// ----------------------------------------------------------------------------
module pmb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               mid_empty,
  input  pmb_pkg::mid_item_t mid_item,
  output logic               mid_pop,
  output logic               out_push,
  output pmb_pkg::bin_t      out_bin,
  input  logic               out_full
);

  import pmb_pkg::*;

  logic                       bin_open;
  logic signed [CTR_BITS-1:0] open_center;
  logic signed [CTR_BITS-1:0] open_end;
  logic [PROB_BITS-1:0]       open_sum;
  logic                       flush;

  logic                       fits;
  logic                       closes;
  logic [PROB_BITS:0]         sum_wide;
  logic                       step;

  assign fits     = bin_open && ($signed({2'b00, mid_item.mass}) <= open_end);
  assign closes   = bin_open && !fits;
  assign sum_wide = {1'b0, open_sum} + {1'b0, mid_item.prob};
  assign step     = !flush && !mid_empty && !(closes && out_full);

  assign mid_pop            = step;
  assign out_push           = flush ? !out_full : (step && closes);
  assign out_bin.bin_center = open_center;
  assign out_bin.prob_sum   = open_sum;
  assign out_bin.last_bin   = flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_open    <= 1'b0;
      open_center <= '0;
      open_end    <= '0;
      open_sum    <= '0;
      flush       <= 1'b0;
    end else if (flush) begin
      if (!out_full) begin
        bin_open    <= 1'b0;
        open_center <= '0;
        open_end    <= '0;
        open_sum    <= '0;
        flush       <= 1'b0;
      end
    end else if (step) begin
      if (fits) begin
        open_sum <= sum_wide[PROB_BITS] ? '1 : sum_wide[PROB_BITS-1:0];
      end else begin
        open_center <= mid_item.center;
        open_end    <= mid_item.bin_end;
        open_sum    <= mid_item.prob;
        bin_open    <= 1'b1;
      end
      flush <= mid_item.last;
    end
  end

endmodule

FILE: sv/peak_mass_binning_core.sv
// ----------------------------------------------------------------------------
// peak_mass_binning_core: fixed-width histogram binning of spectrum peaks
// Sums peak probabilities into fixed-width mass bins and emits each bin.
// ----------------------------------------------------------------------------
// Peaks must arrive in ascending mass order. Each peak word passes through
// the front part's steps in order: accept (FS_IDLE), the bit-serial
// remainder that places the peak in its bin (FS_DIV), forming the center
// (FS_CTR) and handing the word on (FS_PUSH), which waits while the middle
// queue is full; the front takes no new peak until the last one is handed on.
// The back part adds each peak into the open bin and takes no peaks while it
// flushes. A peak beyond the open bin's end closes that bin and emits it;
// the last peak flushes the open bin with last_bin set. Sums saturate at
// all ones. A bin width of zero acts as one LSB. Register writes take effect
// for the next peak accepted; write them only while the block is idle.
module peak_mass_binning_core #(
  parameter int QUEUE_DEPTH = pmb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  pmb_pkg::cfg_reg_t             cfg_index,
  input  logic [pmb_pkg::MASS_BITS-1:0] cfg_data,
  input  logic                          push,
  output logic                          full,
  input  pmb_pkg::peak_t                peak,
  output logic                          empty,
  input  logic                          pop,
  output pmb_pkg::bin_t                 bin
);

  import pmb_pkg::*;

  // Word passed from the front part to the back part.
  mid_item_t mid_in;
  mid_item_t mid_out;
  logic      mid_push;
  logic      mid_full;
  logic      mid_pop;
  logic      mid_empty;

  // Finished bin on its way to the result queue.
  bin_t      out_bin;
  logic      out_push;
  logic      out_full;

  pmb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .peak      (peak),
    .mid_push  (mid_push),
    .mid_item  (mid_in),
    .mid_full  (mid_full)
  );

  // The middle queue lets the front start the next division while the back
  // waits on a full result queue.
  pmb_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (mid_push),
    .wdata (mid_in),
    .full  (mid_full),
    .rd    (mid_pop),
    .rdata (mid_out),
    .empty (mid_empty)
  );

  pmb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_item  (mid_out),
    .mid_pop   (mid_pop),
    .out_push  (out_push),
    .out_bin   (out_bin),
    .out_full  (out_full)
  );

  // The result queue holds finished bin words until the consumer pops them.
  pmb_fifo #(
    .WIDTH ($bits(bin_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (out_push),
    .wdata (out_bin),
    .full  (out_full),
    .rd    (pop),
    .rdata (bin),
    .empty (empty)
  );

endmodule
